### sv/sui_pkg.sv
// Package for the segment intersection unit: widths, channel payload types
// and the record that travels down the divider cell chain. No dependencies.
`default_nettype none
package sui_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIF_W = COORD_BITS + 1;        // coordinate difference
	localparam int PRD_W = 2 * COORD_BITS;        // product of two coordinates
	localparam int CC_W = 2 * COORD_BITS + 1;     // cross product of two points
	localparam int XP_W = 2 * COORD_BITS + 2;     // product of two differences
	localparam int DEN_W = 2 * COORD_BITS + 3;    // d, tn, un
	localparam int PP_W = 2 * COORD_BITS + 2;     // partial product of a numerator
	localparam int NUM_W = 3 * COORD_BITS + 3;    // numerator of a coordinate

	localparam logic [COORD_BITS-1:0] SAT_POS = {1'b0, {(COORD_BITS - 1){1'b1}}};
	localparam logic [COORD_BITS-1:0] SAT_NEG = {1'b1, {(COORD_BITS - 1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] seg1_start_x;
		logic signed [COORD_BITS-1:0] seg1_start_y;
		logic signed [COORD_BITS-1:0] seg1_end_x;
		logic signed [COORD_BITS-1:0] seg1_end_y;
		logic signed [COORD_BITS-1:0] seg2_start_x;
		logic signed [COORD_BITS-1:0] seg2_start_y;
		logic signed [COORD_BITS-1:0] seg2_end_x;
		logic signed [COORD_BITS-1:0] seg2_end_y;
	} query_t;

	typedef struct packed {
		logic                         hit;
		logic                         parallel;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} result_t;

	typedef struct packed {
		logic hit;
		logic parallel;
		logic neg_x;
		logic neg_y;
		logic sat_x;
		logic sat_y;
	} flags_t;

	typedef struct packed {
		logic [NUM_W-1:0]      rem_x;
		logic [NUM_W-1:0]      rem_y;
		logic [DEN_W-1:0]      dmag;
		logic [COORD_BITS-1:0] q_x;
		logic [COORD_BITS-1:0] q_y;
		flags_t                flags;
	} cell_t;

endpackage
`default_nettype wire

### sv/segment_intersection_unit.sv
// Throughput: one query per cycle unless result_ready holds the output;
// seven arithmetic stages feed a chain of COORD_BITS division cells, one
// quotient bit per cell, then an output register.
// Every stage holds its item while the next is full, so bubbles are squeezed out.
// Reset clears all valid flags asynchronously; data registers are not reset.
// Depends on sui_pkg and sui_div_cell.
`default_nettype none
module segment_intersection_unit
	import sui_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_ready,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// stage 1: differences and point products
	logic                    v_s1, en_s1;
	logic signed [DIF_W-1:0] rx_s1, ry_s1, sx_s1, sy_s1, wx_s1, wy_s1;
	logic signed [DIF_W-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [PRD_W-1:0] pa_s1, pb_s1, pc_s1, pd_s1;
	// stage 2: cross product terms
	logic                    v_s2, en_s2;
	logic signed [XP_W-1:0]  m1_s2, m2_s2, m3_s2, m4_s2, m5_s2, m6_s2;
	logic signed [CC_W-1:0]  c1_s2, c2_s2;
	logic signed [DIF_W-1:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2;
	// stage 3: d, tn, un and numerator partial products
	logic                    v_s3, en_s3;
	logic signed [DEN_W-1:0] d_s3, tn_s3, un_s3;
	logic signed [PP_W-1:0]  h1x_s3, l1x_s3, h2x_s3, l2x_s3;
	logic signed [PP_W-1:0]  h1y_s3, l1y_s3, h2y_s3, l2y_s3;
	// stage 4: assembled products, hit test
	logic                    v_s4, en_s4;
	logic signed [NUM_W-1:0] t1x_s4, t2x_s4, t1y_s4, t2y_s4;
	logic [DEN_W-1:0]        dmag_s4;
	logic                    dneg_s4, hit_s4, par_s4;
	// stage 5: numerators
	logic                    v_s5, en_s5;
	logic signed [NUM_W-1:0] nx_s5, ny_s5;
	logic [DEN_W-1:0]        dmag_s5;
	logic                    dneg_s5, hit_s5, par_s5;
	// stage 6: magnitudes and signs
	logic                    v_s6, en_s6;
	logic [NUM_W-1:0]        mx_s6, my_s6;
	logic [DEN_W-1:0]        dmag_s6;
	logic                    negx_s6, negy_s6, hit_s6, par_s6;
	// stage 7: overflow check, head of the cell chain
	logic                    v_s7, en_s7;
	cell_t                   cell_s7;

	logic                    cv [COORD_BITS+1];
	logic                    cr [COORD_BITS+1];
	cell_t                   cd [COORD_BITS+1];

	logic                    out_en;
	result_t                 result_q;
	logic                    result_valid_q;

	logic signed [CC_W-CC_W+COORD_BITS:0] c1h, c1l, c2h, c2l;
	cell_t                   tail;
	logic [COORD_BITS-1:0]   qx, qy;
	result_t                 res_nxt;

	// handshake chain: a stage loads when it is empty or its successor loads
	assign en_s7 = !v_s7 || cr[0];
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign query_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= query_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && query_valid) begin
			rx_s1 <= DIF_W'(query.seg1_end_x) - DIF_W'(query.seg1_start_x);
			ry_s1 <= DIF_W'(query.seg1_end_y) - DIF_W'(query.seg1_start_y);
			sx_s1 <= DIF_W'(query.seg2_end_x) - DIF_W'(query.seg2_start_x);
			sy_s1 <= DIF_W'(query.seg2_end_y) - DIF_W'(query.seg2_start_y);
			wx_s1 <= DIF_W'(query.seg2_start_x) - DIF_W'(query.seg1_start_x);
			wy_s1 <= DIF_W'(query.seg2_start_y) - DIF_W'(query.seg1_start_y);
			dx1_s1 <= DIF_W'(query.seg1_start_x) - DIF_W'(query.seg1_end_x);
			dy1_s1 <= DIF_W'(query.seg1_start_y) - DIF_W'(query.seg1_end_y);
			dx2_s1 <= DIF_W'(query.seg2_start_x) - DIF_W'(query.seg2_end_x);
			dy2_s1 <= DIF_W'(query.seg2_start_y) - DIF_W'(query.seg2_end_y);
			pa_s1 <= PRD_W'(query.seg1_start_x) * PRD_W'(query.seg1_end_y);
			pb_s1 <= PRD_W'(query.seg1_start_y) * PRD_W'(query.seg1_end_x);
			pc_s1 <= PRD_W'(query.seg2_start_x) * PRD_W'(query.seg2_end_y);
			pd_s1 <= PRD_W'(query.seg2_start_y) * PRD_W'(query.seg2_end_x);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			m1_s2 <= XP_W'(rx_s1) * XP_W'(sy_s1);
			m2_s2 <= XP_W'(ry_s1) * XP_W'(sx_s1);
			m3_s2 <= XP_W'(wx_s1) * XP_W'(sy_s1);
			m4_s2 <= XP_W'(wy_s1) * XP_W'(sx_s1);
			m5_s2 <= XP_W'(wx_s1) * XP_W'(ry_s1);
			m6_s2 <= XP_W'(wy_s1) * XP_W'(rx_s1);
			c1_s2 <= CC_W'(pa_s1) - CC_W'(pb_s1);
			c2_s2 <= CC_W'(pc_s1) - CC_W'(pd_s1);
			dx1_s2 <= dx1_s1;
			dy1_s2 <= dy1_s1;
			dx2_s2 <= dx2_s1;
			dy2_s2 <= dy2_s1;
		end
	end

	// The point cross products are split into a signed high half and an
	// unsigned low half so that each multiplier stays near the coordinate width.
	assign c1h = c1_s2[CC_W-1:COORD_BITS];
	assign c2h = c2_s2[CC_W-1:COORD_BITS];
	assign c1l = {1'b0, c1_s2[COORD_BITS-1:0]};
	assign c2l = {1'b0, c2_s2[COORD_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			d_s3 <= DEN_W'(m1_s2) - DEN_W'(m2_s2);
			tn_s3 <= DEN_W'(m3_s2) - DEN_W'(m4_s2);
			un_s3 <= DEN_W'(m5_s2) - DEN_W'(m6_s2);
			h1x_s3 <= PP_W'(c1h) * PP_W'(dx2_s2);
			l1x_s3 <= PP_W'(c1l) * PP_W'(dx2_s2);
			h2x_s3 <= PP_W'(c2h) * PP_W'(dx1_s2);
			l2x_s3 <= PP_W'(c2l) * PP_W'(dx1_s2);
			h1y_s3 <= PP_W'(c1h) * PP_W'(dy2_s2);
			l1y_s3 <= PP_W'(c1l) * PP_W'(dy2_s2);
			h2y_s3 <= PP_W'(c2h) * PP_W'(dy1_s2);
			l2y_s3 <= PP_W'(c2l) * PP_W'(dy1_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			t1x_s4 <= (NUM_W'(h1x_s3) <<< COORD_BITS) + NUM_W'(l1x_s3);
			t2x_s4 <= (NUM_W'(h2x_s3) <<< COORD_BITS) + NUM_W'(l2x_s3);
			t1y_s4 <= (NUM_W'(h1y_s3) <<< COORD_BITS) + NUM_W'(l1y_s3);
			t2y_s4 <= (NUM_W'(h2y_s3) <<< COORD_BITS) + NUM_W'(l2y_s3);
			dmag_s4 <= d_s3[DEN_W-1] ? DEN_W'(-d_s3) : DEN_W'(d_s3);
			dneg_s4 <= d_s3[DEN_W-1];
			par_s4 <= (d_s3 == '0);
			if (d_s3[DEN_W-1]) begin
				hit_s4 <= (tn_s3 <= 0) && (tn_s3 >= d_s3) && (un_s3 <= 0) && (un_s3 >= d_s3);
			end else begin
				hit_s4 <= (d_s3 != '0) && (tn_s3 >= 0) && (tn_s3 <= d_s3)
				          && (un_s3 >= 0) && (un_s3 <= d_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			nx_s5 <= t1x_s4 - t2x_s4;
			ny_s5 <= t1y_s4 - t2y_s4;
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;
			hit_s5 <= hit_s4;
			par_s5 <= par_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			mx_s6 <= nx_s5[NUM_W-1] ? NUM_W'(-nx_s5) : NUM_W'(nx_s5);
			my_s6 <= ny_s5[NUM_W-1] ? NUM_W'(-ny_s5) : NUM_W'(ny_s5);
			negx_s6 <= nx_s5[NUM_W-1] ^ dneg_s5;
			negy_s6 <= ny_s5[NUM_W-1] ^ dneg_s5;
			dmag_s6 <= dmag_s5;
			hit_s6 <= hit_s5;
			par_s6 <= par_s5;
		end
	end

	// A quotient of 2^COORD_BITS or more saturates in any case, so the cells
	// only ever need to produce COORD_BITS quotient bits.
	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			cell_s7.rem_x <= mx_s6;
			cell_s7.rem_y <= my_s6;
			cell_s7.dmag <= dmag_s6;
			cell_s7.q_x <= '0;
			cell_s7.q_y <= '0;
			cell_s7.flags.hit <= hit_s6;
			cell_s7.flags.parallel <= par_s6;
			cell_s7.flags.neg_x <= negx_s6;
			cell_s7.flags.neg_y <= negy_s6;
			cell_s7.flags.sat_x <= (mx_s6 >= (NUM_W'(dmag_s6) << COORD_BITS));
			cell_s7.flags.sat_y <= (my_s6 >= (NUM_W'(dmag_s6) << COORD_BITS));
		end
	end

	assign cv[0] = v_s7;
	assign cd[0] = cell_s7;

	for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
		sui_div_cell #(
			.SHIFT(COORD_BITS - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(cv[k]),
			.up_ready(cr[k]),
			.up_data (cd[k]),
			.dn_valid(cv[k+1]),
			.dn_ready(cr[k+1]),
			.dn_data (cd[k+1])
		);
	end

	assign out_en = !result_valid_q || result_ready;
	assign cr[COORD_BITS] = out_en;
	assign tail = cd[COORD_BITS];

	always_comb begin
		qx = tail.q_x;
		qy = tail.q_y;
		if (tail.flags.neg_x) begin
			if (tail.flags.sat_x || qx > SAT_NEG) qx = SAT_NEG;
		end else begin
			if (tail.flags.sat_x || qx > SAT_POS) qx = SAT_POS;
		end
		if (tail.flags.neg_y) begin
			if (tail.flags.sat_y || qy > SAT_NEG) qy = SAT_NEG;
		end else begin
			if (tail.flags.sat_y || qy > SAT_POS) qy = SAT_POS;
		end
		res_nxt.hit = tail.flags.hit;
		res_nxt.parallel = tail.flags.parallel;
		res_nxt.point_x = tail.flags.neg_x ? -qx : qx;
		res_nxt.point_y = tail.flags.neg_y ? -qy : qy;
		if (tail.flags.parallel) begin
			res_nxt.hit = 1'b0;
			res_nxt.point_x = '0;
			res_nxt.point_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_en) begin
			result_valid_q <= cv[COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && cv[COORD_BITS]) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// Input may only back up when the whole pipeline is full behind a stalled output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!query_ready |-> (result_valid && !result_ready && v_s1 && v_s7))
		else $error("query stalled while pipeline has room");

	a_parallel_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.parallel) |->
		(!result.hit && result.point_x == '0 && result.point_y == '0))
		else $error("parallel result carries a hit or a point");

	a_cell_input_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !cell_s7.flags.sat_x) |->
		(cell_s7.rem_x < (NUM_W'(cell_s7.dmag) << COORD_BITS)))
		else $error("unsaturated numerator too large for the cell chain");
`endif

endmodule
`default_nettype wire

### sv/sui_div_cell.sv
// One restoring division cell: settles one quotient bit for both coordinates.
// Depends on sui_pkg for the cell record.
`default_nettype none
module sui_div_cell
	import sui_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  cell_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output cell_t dn_data
);

	logic             valid_q;
	cell_t            data_q;
	cell_t            nxt;
	logic [NUM_W-1:0] dsh;
	logic [NUM_W:0]   tx;
	logic [NUM_W:0]   ty;

	assign dsh = NUM_W'(up_data.dmag) << SHIFT;
	assign tx = {1'b0, up_data.rem_x} - {1'b0, dsh};
	assign ty = {1'b0, up_data.rem_y} - {1'b0, dsh};

	always_comb begin
		nxt = up_data;
		if (!tx[NUM_W]) begin
			nxt.rem_x = tx[NUM_W-1:0];
			nxt.q_x[SHIFT] = 1'b1;
		end
		if (!ty[NUM_W]) begin
			nxt.rem_y = ty[NUM_W-1:0];
			nxt.q_y[SHIFT] = 1'b1;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule
`default_nettype wire

### test/tb_segment_intersection_unit.sv
// Testbench for segment_intersection_unit: directed and random segment pairs,
// each result checked against an exact integer predictor of the geometry.
// Depends on sui_pkg and the segment_intersection_unit RTL.
`timescale 1ns / 100ps
module tb_segment_intersection_unit;
	import sui_pkg::*;

	localparam int N_RANDOM = 930;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = COORD_BITS + 20;
	localparam logic signed [COORD_BITS-1:0] CMAX = SAT_POS;
	localparam logic signed [COORD_BITS-1:0] CMIN = SAT_NEG;

	typedef struct {
		query_t  q;
		logic    known;
		result_t r;
	} directed_row_t;

	logic    clk;
	logic    arst_n;
	logic    query_valid;
	logic    query_ready;
	query_t  query;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t       pending_results[$];
	directed_row_t directed_rows[$];
	int            error_count;
	int            idle_cycles;
	int            queries_sent;
	int            results_seen;
	int            hits_seen;
	int            parallels_seen;
	int            saturations_seen;
	bit            stimulus_done;
	bit            hold_off_done;

	segment_intersection_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query(query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Truncating division of an exact numerator, saturated to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] quotient_sat(
			input logic signed [127:0] num, input logic signed [127:0] den);
		logic signed [127:0] quo;
		quo = num / den;
		if (quo > 128'(signed'(CMAX)))
			return CMAX;
		if (quo < 128'(signed'(CMIN)))
			return CMIN;
		return quo[COORD_BITS-1:0];
	endfunction

	function automatic result_t intersect_segments(input query_t q);
		longint a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;
		longint rx, ry, sx, sy, wx, wy, d, tn, un, c1, c2;
		logic signed [127:0] nx, ny;
		result_t r;
		a1x = q.seg1_start_x; a1y = q.seg1_start_y;
		b1x = q.seg1_end_x;   b1y = q.seg1_end_y;
		a2x = q.seg2_start_x; a2y = q.seg2_start_y;
		b2x = q.seg2_end_x;   b2y = q.seg2_end_y;
		rx = b1x - a1x; ry = b1y - a1y;
		sx = b2x - a2x; sy = b2y - a2y;
		wx = a2x - a1x; wy = a2y - a1y;
		d = rx * sy - ry * sx;
		r = '0;
		if (d == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		tn = wx * sy - wy * sx;
		un = wx * ry - wy * rx;
		if (d > 0)
			r.hit = tn >= 0 && tn <= d && un >= 0 && un <= d;
		else
			r.hit = tn <= 0 && tn >= d && un <= 0 && un >= d;
		c1 = a1x * b1y - a1y * b1x;
		c2 = a2x * b2y - a2y * b2x;
		nx = 128'(signed'(c1)) * 128'(signed'(a2x - b2x))
			- 128'(signed'(c2)) * 128'(signed'(a1x - b1x));
		ny = 128'(signed'(c1)) * 128'(signed'(a2y - b2y))
			- 128'(signed'(c2)) * 128'(signed'(a1y - b1y));
		r.point_x = quotient_sat(nx, 128'(signed'(d)));
		r.point_y = quotient_sat(ny, 128'(signed'(d)));
		return r;
	endfunction

	function automatic query_t make_query(input int ax, ay, bx, by, cx, cy, ex, ey);
		query_t q;
		q.seg1_start_x = ax[COORD_BITS-1:0];
		q.seg1_start_y = ay[COORD_BITS-1:0];
		q.seg1_end_x = bx[COORD_BITS-1:0];
		q.seg1_end_y = by[COORD_BITS-1:0];
		q.seg2_start_x = cx[COORD_BITS-1:0];
		q.seg2_start_y = cy[COORD_BITS-1:0];
		q.seg2_end_x = ex[COORD_BITS-1:0];
		q.seg2_end_y = ey[COORD_BITS-1:0];
		return q;
	endfunction

	function automatic result_t make_result(input logic h, input logic p, input int x,
			input int y);
		result_t r;
		r.hit = h;
		r.parallel = p;
		r.point_x = x[COORD_BITS-1:0];
		r.point_y = y[COORD_BITS-1:0];
		return r;
	endfunction

	// Mostly small coordinates so segments often cross, sometimes full range.
	function automatic logic [COORD_BITS-1:0] random_coord(input int spread);
		case (spread)
			0: return COORD_BITS'($urandom_range(40) - 20);
			1: return COORD_BITS'($urandom_range(4000) - 2000);
			2: return ($urandom_range(1) != 0) ? CMAX - COORD_BITS'($urandom_range(3))
				: CMIN + COORD_BITS'($urandom_range(3));
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int spread;
		int kind;
		spread = ($urandom_range(9) < 5) ? 0 : int'($urandom_range(3));
		q = '0;
		q.seg1_start_x = random_coord(spread);
		q.seg1_start_y = random_coord(spread);
		q.seg1_end_x = random_coord(spread);
		q.seg1_end_y = random_coord(spread);
		q.seg2_start_x = random_coord(spread);
		q.seg2_start_y = random_coord(spread);
		q.seg2_end_x = random_coord(spread);
		q.seg2_end_y = random_coord(spread);
		kind = $urandom_range(9);
		if (kind == 0) begin
			// Parallel: second direction is a multiple of the first.
			q.seg2_end_x = q.seg2_start_x + (q.seg1_end_x - q.seg1_start_x);
			q.seg2_end_y = q.seg2_start_y + (q.seg1_end_y - q.seg1_start_y);
		end else if (kind == 1) begin
			// Segments that share an endpoint.
			q.seg2_start_x = q.seg1_end_x;
			q.seg2_start_y = q.seg1_end_y;
		end
		return q;
	endfunction

	function automatic int gap_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return 0;
		if (pick < 90)
			return $urandom_range(3);
		return $urandom_range(40);
	endfunction

	// Valid drops only for a gap, so back-to-back transfers keep it high.
	task automatic send_query(input query_t q);
		int gap;
		gap = gap_length();
		if (gap != 0) begin
			query_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_valid <= 1'b1;
		query <= q;
		pending_results.push_back(intersect_segments(q));
		@(posedge clk);
		while (!query_ready)
			@(posedge clk);
		queries_sent++;
	endtask

	task automatic wait_for_drain();
		query_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		error_count = 0;
		queries_sent = 0;
		stimulus_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows.push_back('{make_query(0, 0, 10, 10, 0, 10, 10, 0), 1'b1,
			make_result(1, 0, 5, 5)});
		directed_rows.push_back('{make_query(0, 0, 10, 0, 0, 5, 10, 5), 1'b1,
			make_result(0, 1, 0, 0)});
		directed_rows.push_back('{make_query(0, 0, 10, 0, 5, 0, 20, 0), 1'b1,
			make_result(0, 1, 0, 0)});
		directed_rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			make_result(0, 1, 0, 0)});
		directed_rows.push_back('{make_query(0, 0, 10, 0, 10, 0, 10, 10), 1'b1,
			make_result(1, 0, 10, 0)});
		directed_rows.push_back('{make_query(0, 0, 10, 0, 11, -5, 11, 5), 1'b1,
			make_result(0, 0, 11, 0)});
		directed_rows.push_back('{make_query(0, 0, 3, 1, 0, 1, 3, 0), 1'b0, '0});
		directed_rows.push_back('{make_query(0, 0, -3, -1, 0, -1, -3, 0), 1'b0, '0});
		directed_rows.push_back('{make_query(-32768, -32768, 32767, 32767, -32768, 32767,
			32767, -32768), 1'b0, '0});
		directed_rows.push_back('{make_query(32767, 32767, -32768, -32768, 32767, -32768,
			-32768, 32767), 1'b0, '0});
		// Nearly parallel lines that meet near the edge of the coordinate range.
		directed_rows.push_back('{make_query(0, 0, 32767, 1, 0, 1, 32767, 1), 1'b0, '0});
		directed_rows.push_back('{make_query(0, 0, -32768, 1, 0, 1, -32768, 1), 1'b0, '0});
		directed_rows.push_back('{make_query(0, 0, 32767, 1, 0, -1, 32767, -1), 1'b0, '0});
		directed_rows.push_back('{make_query(-32768, 0, 32767, 0, 0, -32768, 0, 32767),
			1'b1, make_result(1, 0, 0, 0)});
		directed_rows.push_back('{make_query(32767, -32768, -32768, 32767, 1, 1, 2, 3),
			1'b0, '0});
		directed_rows.push_back('{make_query(-1, -1, -1, -1, 5, 5, 6, 6), 1'b1,
			make_result(0, 1, 0, 0)});
		directed_rows.push_back('{make_query(-21846, 21845, 21845, -21846, -1, -1, 1, 1),
			1'b0, '0});

		foreach (directed_rows[i]) begin
			if (directed_rows[i].known
					&& directed_rows[i].r != intersect_segments(directed_rows[i].q)) begin
				$display("%0t: directed row %0d table %h predictor %h", $time, i,
					directed_rows[i].r, intersect_segments(directed_rows[i].q));
				error_count++;
			end
			send_query(directed_rows[i].q);
		end

		// Halfway through, the sender pauses until every pending result is back.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				wait_for_drain();
			send_query(random_query());
		end
		query_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver: random stalls, one long hold-off once the sender is busy again.
	initial begin
		int stall;
		result_ready = 1'b0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_off_done && queries_sent > 600) begin
				result_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off_done = 1'b1;
			end
			stall = gap_length();
			if ($urandom_range(3) == 0 && stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.hit !== want.hit) begin
					$display("%0t: hit expected %b actual %b", $time, want.hit, result.hit);
					error_count++;
				end
				if (result.parallel !== want.parallel) begin
					$display("%0t: parallel expected %b actual %b", $time, want.parallel,
						result.parallel);
					error_count++;
				end
				if (result.point_x !== want.point_x) begin
					$display("%0t: point_x expected %0d actual %0d", $time, want.point_x,
						result.point_x);
					error_count++;
				end
				if (result.point_y !== want.point_y) begin
					$display("%0t: point_y expected %0d actual %0d", $time, want.point_y,
						result.point_y);
					error_count++;
				end
				hits_seen += want.hit;
				parallels_seen += want.parallel;
				if (want.point_x == CMAX || want.point_x == CMIN)
					saturations_seen++;
			end
		end
	end

	// Watchdog and end of run.
	initial begin
		idle_cycles = 0;
		results_seen = 0;
		hits_seen = 0;
		parallels_seen = 0;
		saturations_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((query_valid && query_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
			if (stimulus_done && pending_results.size() == 0) begin
				repeat (DRAIN_CYCLES) @(posedge clk);
				$display("Covered %0d queries, %0d results: %0d hits, %0d parallel,",
					queries_sent, results_seen, hits_seen, parallels_seen);
				$display("%0d saturated x, with stalls on both sides.", saturations_seen);
				if (error_count == 0)
					$display("Test completed successfully");
				else
					$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

### segment_intersection_unit.f
sv/sui_pkg.sv
sv/sui_div_cell.sv
sv/segment_intersection_unit.sv
test/tb_segment_intersection_unit.sv
